>>> rtl/core/vps_pkg.sv
// vps_pkg: shared types, constants and helpers for the vertex projection unit
// no dependencies; imported by every module under rtl/core
package vps_pkg;

  // default fixed point format: Q16.16
  localparam int VPS_FRAC_BITS = 16;

  // matrix store: modelview at 0..15, projection at 16..31
  localparam int MAT_DEPTH = 32;
  localparam int MAT_AW    = 5;

  // multiply-accumulate schedule: 16 eye-space ops then 12 clip-space ops
  localparam int OPS_TOTAL = 28;
  localparam int OP_W      = 5;

  // divider: 32 quotient bits, two bits per cycle
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VIEW_LEFT   = 2'd0;
  localparam cfg_idx_t CFG_VIEW_TOP    = 2'd1;
  localparam cfg_idx_t CFG_VIEW_WIDTH  = 2'd2;
  localparam cfg_idx_t CFG_VIEW_HEIGHT = 2'd3;

  localparam logic [12:0] VIEW_LEFT_RST   = 13'd0;
  localparam logic [12:0] VIEW_TOP_RST    = 13'd0;
  localparam logic [13:0] VIEW_WIDTH_RST  = 14'd640;
  localparam logic [13:0] VIEW_HEIGHT_RST = 14'd480;

  // item modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD_MV = 2'd0;
  localparam mode_t MODE_LOAD_PJ = 2'd1;
  localparam mode_t MODE_PROJECT = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } vps_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
  } vps_result_t;

  typedef struct packed {
    logic [12:0] left;
    logic [12:0] top;
    logic [13:0] width;
    logic [13:0] height;
  } vps_view_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_VP_X,
    ST_VP_Y,
    ST_FINISH,
    ST_DONE
  } vps_state_t;

  // one multiply-accumulate op in flight
  typedef struct packed {
    logic       pass;     // add the element itself (translation column)
    logic       first;    // restart the accumulator
    logic       last;     // write the row result
    logic       is_clip;  // projection phase, operand from eye vector
    logic [1:0] row;
    logic [1:0] sel;      // operand index
  } vps_op_t;

  typedef struct packed {
    logic             start;
    logic [2:0][31:0] clip;
    logic [31:0]      eye_z;
  } vps_div_req_t;

  typedef struct packed {
    logic             done;
    logic [2:0][31:0] ndc;
  } vps_div_rsp_t;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/vertex_project_to_screen.sv
// vertex_project_to_screen: top level of the vertex projection unit
// depends on vps_pkg, vps_mat_mem, vps_div and vps_core
//
// Usage:
// - item channel (item_valid/item_ready/item): mode 0 and 1 transfers write one
//   modelview or projection element in the transfer cycle and give no result;
//   mode 2 projects a point; mode 3 is dropped
// - result channel (result_valid/result_ready/result): one transfer per
//   projected point, valid_res low with zero coordinates when eye z is zero
// - cfg_wr_en/cfg_index/cfg_wdata write the viewport registers; the user must
//   write them only while the unit is idle, the block does not enforce it
// - a new item is taken in the same cycle that a projected point shows on
//   result_valid, so no item is taken while a point is in progress; loads
//   are taken at one per cycle while the unit is idle
// - a point goes through 28 multiply-accumulates on the single matrix memory
//   read port and multiplier, then through the divider unless eye z is zero
// - reset clears both matrices to zero and loads viewport 0,0,640,480
// - when the receiver stalls the finished result stays in the output
//   register and the next point is computed; it waits only if that one
//   finishes before the output register is freed
module vertex_project_to_screen
  import vps_pkg::*;
#(
  parameter int FRAC_BITS = VPS_FRAC_BITS
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  vps_item_t             item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output vps_result_t           result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  vps_view_t          view;
  logic               mem_we;
  logic [MAT_AW-1:0]  mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [MAT_AW-1:0]  mem_raddr;
  logic signed [31:0] mem_rdata;
  vps_div_req_t       div_req;
  vps_div_rsp_t       div_rsp;
  logic               out_room;
  logic               res_load;
  vps_result_t        res;

  // viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view.left   <= VIEW_LEFT_RST;
      view.top    <= VIEW_TOP_RST;
      view.width  <= VIEW_WIDTH_RST;
      view.height <= VIEW_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_VIEW_LEFT:   view.left   <= cfg_wdata[12:0];
        CFG_VIEW_TOP:    view.top    <= cfg_wdata[12:0];
        CFG_VIEW_WIDTH:  view.width  <= cfg_wdata[13:0];
        CFG_VIEW_HEIGHT: view.height <= cfg_wdata[13:0];
      endcase
    end
  end

  // output register: free when empty or being transferred
  assign out_room = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

  vps_mat_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vps_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  vps_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .view       (view),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_room   (out_room),
    .res_load   (res_load),
    .res        (res)
  );

endmodule

>>> rtl/core/vps_mat_mem.sv
// vps_mat_mem: 32 x 32 bit matrix store, one write and one registered read port
// depends on vps_pkg; entries read as zero until first written after reset
module vps_mat_mem
  import vps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [MAT_AW-1:0]   waddr,
  input  logic signed [31:0]  wdata,
  input  logic [MAT_AW-1:0]   raddr,
  output logic signed [31:0]  rdata
);

  logic signed [31:0]   mem [MAT_DEPTH];
  logic [MAT_DEPTH-1:0] vld;
  logic signed [31:0]   rd_q;
  logic                 rd_vld;

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

>>> rtl/core/vps_div.sv
// vps_div: three-lane radix-2 restoring divider, two quotient bits per cycle
// depends on vps_pkg; computes sat32(clip * 2^FRAC_BITS / -eye_z) per lane
module vps_div
  import vps_pkg::*;
#(
  parameter int FRAC_BITS = VPS_FRAC_BITS
)
(
  input  logic         clk,
  input  logic         rst,
  input  vps_div_req_t req,
  output vps_div_rsp_t rsp
);

  localparam int LANES = 3;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          dvs;
  logic [31:0]          mag_d;

  logic [31:0] rem  [LANES];
  logic [31:0] nlo  [LANES];
  logic [31:0] quo  [LANES];
  logic        ovf  [LANES];
  logic        neg  [LANES];

  logic [31:0] mag_c    [LANES];
  logic [63:0] num      [LANES];
  logic [31:0] rem_init [LANES];
  logic [31:0] nlo_init [LANES];
  logic        ovf_init [LANES];
  logic        neg_init [LANES];

  logic [31:0] rem_nx [LANES];
  logic [31:0] nlo_nx [LANES];
  logic [1:0]  qb_nx  [LANES];
  logic [32:0] trial;

  // operand setup: magnitudes, sign of quotient, early overflow check
  always_comb begin
    mag_d = req.eye_z[31] ? -req.eye_z : req.eye_z;
    for (int l = 0; l < LANES; l++) begin
      mag_c[l]    = req.clip[l][31] ? -req.clip[l] : req.clip[l];
      num[l]      = {32'd0, mag_c[l]} << FRAC_BITS;
      rem_init[l] = num[l][63:32];
      nlo_init[l] = num[l][31:0];
      // quotient of 2^32 or more always saturates
      ovf_init[l] = (rem_init[l] >= mag_d);
      // divisor is -eye_z: negative when eye_z is positive
      neg_init[l] = req.clip[l][31] ^ ~req.eye_z[31];
    end
  end

  // two restoring steps per lane per cycle
  always_comb begin
    trial = '0;
    for (int l = 0; l < LANES; l++) begin
      rem_nx[l] = rem[l];
      nlo_nx[l] = nlo[l];
      qb_nx[l]  = 2'b00;
      for (int b = 0; b < 2; b++) begin
        trial     = {rem_nx[l], nlo_nx[l][31]};
        nlo_nx[l] = nlo_nx[l] << 1;
        if (trial >= {1'b0, dvs}) begin
          trial         = trial - {1'b0, dvs};
          qb_nx[l][1-b] = 1'b1;
        end
        rem_nx[l] = trial[31:0];
      end
    end
  end

  // control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // lane datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs <= mag_d;
    end
    for (int l = 0; l < LANES; l++) begin
      if (req.start) begin
        rem[l] <= rem_init[l];
        nlo[l] <= nlo_init[l];
        ovf[l] <= ovf_init[l];
        neg[l] <= neg_init[l];
        quo[l] <= '0;
      end else if (busy) begin
        rem[l] <= rem_nx[l];
        nlo[l] <= nlo_nx[l];
        quo[l] <= {quo[l][29:0], qb_nx[l]};
      end
    end
  end

  // sign and saturation of the quotients
  always_comb begin
    rsp.done = done;
    for (int l = 0; l < LANES; l++) begin
      if (ovf[l] || quo[l][31]) begin
        rsp.ndc[l] = neg[l] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        rsp.ndc[l] = neg[l] ? -quo[l] : quo[l];
      end
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> done)
    else $error("divider missed completion");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still iterating");
`endif

endmodule

>>> rtl/core/vps_core.sv
// vps_core: item sequencer, shared multiply-accumulate pipeline and viewport map
// depends on vps_pkg; drives vps_mat_mem ports and the vps_div request
module vps_core
  import vps_pkg::*;
#(
  parameter int FRAC_BITS = VPS_FRAC_BITS
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  vps_item_t          item,
  input  vps_view_t          view,
  output logic               mem_we,
  output logic [MAT_AW-1:0]  mem_waddr,
  output logic signed [31:0] mem_wdata,
  output logic [MAT_AW-1:0]  mem_raddr,
  input  logic signed [31:0] mem_rdata,
  output vps_div_req_t       div_req,
  input  vps_div_rsp_t       div_rsp,
  input  logic               out_room,
  output logic               res_load,
  output vps_result_t        res
);

  localparam logic signed [32:0] ONE_33 = 33'sd1 << FRAC_BITS;
  localparam logic signed [33:0] ONE_34 = 34'sd1 << FRAC_BITS;

  vps_state_t state, state_next;

  logic [OP_W-1:0]    issue;
  logic               iss_on;
  vps_op_t            op0, op1, op2;
  logic               s1_vld, s2_vld;
  logic signed [31:0] opnd;
  logic signed [63:0] prod;
  logic signed [63:0] s1_val, s2_val;
  logic signed [63:0] acc, sum;
  logic               mac_done;
  logic               proj_take;

  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] eye  [4];
  logic signed [31:0] clip [3];
  logic signed [31:0] ndc  [3];

  logic signed [31:0] vp_a;
  logic [13:0]        vp_b;
  logic signed [32:0] vp_sum;
  logic signed [47:0] vp_prod;
  logic signed [47:0] vp_px, vp_py;
  logic signed [49:0] half_x, half_y, left_w, top_w, height_w, sx, sy;
  logic signed [33:0] dz;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    mem_we     = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          mem_we = (item.mode == MODE_LOAD_MV) || (item.mode == MODE_LOAD_PJ);
          if (item.mode == MODE_PROJECT) begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        state_next = (eye[2] == '0) ? ST_DONE : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_VP_X;
        end
      end
      ST_VP_X:   state_next = ST_VP_Y;
      ST_VP_Y:   state_next = ST_FINISH;
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (out_room) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  assign proj_take = (state == ST_IDLE) && item_valid && (item.mode == MODE_PROJECT);
  assign mem_waddr = {item.mode[0], item.elem_index};
  assign mem_wdata = item.elem_value;

  // op decode: issue 0..15 build eye rows, 16..27 build clip rows
  always_comb begin
    op0 = '0;
    op0.row = issue[3:2];
    if (!issue[4]) begin
      op0.pass  = (issue[1:0] == 2'd0);
      op0.first = (issue[1:0] == 2'd0);
      op0.last  = (issue[1:0] == 2'd3);
      op0.sel   = issue[1:0] - 2'd1;
      // translation column sits at element 12+row
      mem_raddr = op0.pass ? {3'b011, op0.row} : {1'b0, op0.sel, op0.row};
    end else begin
      op0.is_clip = 1'b1;
      op0.first   = (issue[1:0] == 2'd0);
      op0.last    = (issue[1:0] == 2'd3);
      op0.sel     = issue[1:0];
      mem_raddr   = {1'b1, op0.sel, op0.row};
    end
  end

  assign iss_on = (state == ST_MAC) && (issue != OP_W'(OPS_TOTAL));

  // stage 1: element from memory times operand, or the element itself (translation column)
  always_comb begin
    if (op1.is_clip) begin
      opnd = eye[op1.sel];
    end else begin
      unique case (op1.sel)
        2'd0:    opnd = pos_x;
        2'd1:    opnd = pos_y;
        default: opnd = pos_z;
      endcase
    end
    prod   = mem_rdata * opnd;
    s1_val = op1.pass ? $signed({{32{mem_rdata[31]}}, mem_rdata}) : (prod >>> FRAC_BITS);
  end

  // stage 2: accumulate
  assign sum      = (op2.first ? 64'sd0 : acc) + s2_val;
  assign mac_done = s2_vld && op2.last && op2.is_clip && (op2.row == 2'd2);

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= '0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= iss_on;
      s2_vld <= s1_vld;
      if (state == ST_IDLE) begin
        issue <= '0;
      end else if (iss_on) begin
        issue <= issue + 1'b1;
      end
    end
  end

  // multiply-accumulate datapath and row results
  always_ff @(posedge clk) begin
    op1    <= op0;
    op2    <= op1;
    s2_val <= s1_val;
    if (proj_take) begin
      pos_x <= item.pos_x;
      pos_y <= item.pos_y;
      pos_z <= item.pos_z;
    end
    if (s2_vld) begin
      acc <= sum;
      if (op2.last) begin
        if (!op2.is_clip) begin
          eye[op2.row] <= sat32(sum);
        end else begin
          unique case (op2.row)
            2'd0:    clip[0] <= sat32(sum);
            2'd1:    clip[1] <= sat32(sum);
            default: clip[2] <= sat32(sum);
          endcase
        end
      end
    end
  end

  // divider request
  always_comb begin
    div_req.start   = (state == ST_DIV_START) && (eye[2] != '0);
    div_req.clip[0] = clip[0];
    div_req.clip[1] = clip[1];
    div_req.clip[2] = clip[2];
    div_req.eye_z   = eye[2];
  end

  // viewport multiplier, shared between x and y
  always_comb begin
    vp_a    = (state == ST_VP_X) ? ndc[0] : ndc[1];
    vp_b    = (state == ST_VP_X) ? view.width : view.height;
    vp_sum  = $signed({vp_a[31], vp_a}) + ONE_33;
    vp_prod = vp_sum * $signed({1'b0, vp_b});
  end

  // final screen mapping
  always_comb begin
    half_x   = $signed({{2{vp_px[47]}}, vp_px}) >>> 1;
    half_y   = $signed({{2{vp_py[47]}}, vp_py}) >>> 1;
    left_w   = $signed({37'd0, view.left}) <<< FRAC_BITS;
    top_w    = $signed({37'd0, view.top}) <<< FRAC_BITS;
    height_w = $signed({36'd0, view.height}) <<< FRAC_BITS;
    sx       = half_x + left_w;
    sy       = height_w - (half_y + top_w);
    dz       = ($signed({{2{ndc[2][31]}}, ndc[2]}) + ONE_34) >>> 1;
  end

  // divider results, viewport products, result register
  always_ff @(posedge clk) begin
    if (state == ST_DIV_WAIT && div_rsp.done) begin
      ndc[0] <= $signed(div_rsp.ndc[0]);
      ndc[1] <= $signed(div_rsp.ndc[1]);
      ndc[2] <= $signed(div_rsp.ndc[2]);
    end
    if (state == ST_VP_X) begin
      vp_px <= vp_prod;
    end
    if (state == ST_VP_Y) begin
      vp_py <= vp_prod;
    end
    if (state == ST_DIV_START && eye[2] == '0) begin
      res <= '0;
    end else if (state == ST_FINISH) begin
      res.valid_res <= 1'b1;
      res.screen_x  <= sat32({{14{sx[49]}}, sx});
      res.screen_y  <= sat32({{14{sy[49]}}, sy});
      res.depth     <= sat32({{30{dz[33]}}, dz});
    end
  end

`ifndef ASSERT_OFF
  a_mac_drained: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (issue == OP_W'(OPS_TOTAL)) && !s1_vld)
    else $error("clip rows finished with ops still in flight");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !s1_vld && !s2_vld)
    else $error("mac pipeline busy while idle");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside wait state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (state == ST_DIV_START) && (div_req.eye_z != '0))
    else $error("divider started with zero divisor");
`endif

endmodule
